@@ sv/delta_timer_queue_assert.svh @@
// assertion macros shared by the checker
`ifndef DELTA_TIMER_QUEUE_ASSERT_SVH
`define DELTA_TIMER_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define DTQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("delta timer queue check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define DTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("delta timer queue check failed");

`endif

@@ sv/dtq_pkg.sv @@
`timescale 1ns / 1ps

package dtq_pkg;

    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned POP_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [15:0] FOREVER    = 16'hFFFF;
    localparam logic [15:0] DELTA_SAT  = 16'hFFFE;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EXPIRED   = 3'd3;
    localparam logic [2:0] ST_NONE      = 3'd4;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic        start;
        logic        step;
        logic        apply;
        logic        ins;
        logic        fe;
        logic        found;
        logic        dec;
        logic        pop;
        logic [15:0] key;
        logic [15:0] init_rem;
    } dtq_ctl_t;

    // what a cell shows to its neighbors
    typedef struct packed {
        logic        occ;
        logic        tok;
        logic        fwd;
        logic [15:0] fwd_rem;
        logic [15:0] rem;
        logic [15:0] id;
        logic [15:0] delta;
    } dtq_nbr_t;

endpackage

@@ sv/dtq_cell.sv @@
`timescale 1ns / 1ps

module dtq_cell
    import dtq_pkg::*;
#(
    parameter int unsigned CNT_W = 5,
    parameter int unsigned IDX   = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  dtq_ctl_t         ctl,
    input  logic [CNT_W-1:0] count,
    input  dtq_nbr_t         left_n,
    input  dtq_nbr_t         right_n,
    output dtq_nbr_t         self_n,
    output logic             stop,
    output logic             match
);

    localparam logic [CNT_W-1:0] IDX_C   = CNT_W'(IDX);
    localparam logic             IS_HEAD = (IDX == 0);

    logic [15:0] id_reg, id_next;
    logic [15:0] delta_reg, delta_next;
    logic [15:0] rem_reg, rem_next;
    logic        tok_reg, tok_next;
    logic        passed_reg, passed_next;

    logic        occ;
    logic        fin;
    logic        pass;
    logic        left_cut;
    logic        merge;
    logic [16:0] sum;
    logic [15:0] merged;

    // local view of the entry and of the walking token
    assign occ  = IDX_C < count;
    assign fin  = delta_reg != FOREVER;
    assign pass = ctl.ins ? (occ && (ctl.fe || (fin && delta_reg <= rem_reg)))
                          : (occ && id_reg != ctl.key);

    assign stop  = tok_reg && !pass;
    assign match = tok_reg && occ && !ctl.ins && id_reg == ctl.key;

    assign self_n.occ     = occ;
    assign self_n.tok     = tok_reg;
    assign self_n.fwd     = tok_reg && pass;
    assign self_n.fwd_rem = ctl.fe ? rem_reg : rem_reg - delta_reg;
    assign self_n.rem     = rem_reg;
    assign self_n.id      = id_reg;
    assign self_n.delta   = delta_reg;

    // successor of a new entry gives up the part of its wait now covered
    assign left_cut = left_n.tok && left_n.occ && left_n.delta != FOREVER && !ctl.fe;

    // a removed entry hands its wait to a finite successor, saturating
    assign sum    = {1'b0, delta_reg} + {1'b0, right_n.delta};
    assign merge  = fin && right_n.occ && right_n.delta != FOREVER;
    assign merged = (sum > {1'b0, DELTA_SAT}) ? DELTA_SAT : sum[15:0];

    // next state
    always_comb begin
        id_next     = id_reg;
        delta_next  = delta_reg;
        rem_next    = rem_reg;
        tok_next    = tok_reg;
        passed_next = passed_reg;
        if (ctl.start) begin
            tok_next    = IS_HEAD;
            passed_next = 1'b0;
            rem_next    = ctl.init_rem;
        end else if (ctl.step) begin
            if (ctl.apply) begin
                tok_next = 1'b0;
                if (ctl.ins) begin
                    if (tok_reg) begin
                        id_next    = ctl.key;
                        delta_next = rem_reg;
                    end else if (!passed_reg) begin
                        id_next    = left_n.id;
                        delta_next = left_cut ? left_n.delta - left_n.rem : left_n.delta;
                    end
                end else if (ctl.found) begin
                    if (tok_reg || !passed_reg) begin
                        id_next    = right_n.id;
                        delta_next = (tok_reg && merge) ? merged : right_n.delta;
                    end
                end
            end else begin
                tok_next    = left_n.fwd;
                rem_next    = left_n.fwd_rem;
                passed_next = passed_reg | tok_reg;
            end
        end else if (ctl.dec) begin
            if (IS_HEAD && occ && fin && delta_reg != 16'd0) begin
                delta_next = delta_reg - 16'd1;
            end
        end else if (ctl.pop) begin
            id_next    = right_n.id;
            delta_next = right_n.delta;
        end
    end

    // token control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg    <= 1'b0;
            passed_reg <= 1'b0;
        end else begin
            tok_reg    <= tok_next;
            passed_reg <= passed_next;
        end
    end

    // entry payload
    always_ff @(posedge aclk) begin
        id_reg    <= id_next;
        delta_reg <= delta_next;
        rem_reg   <= rem_next;
    end

endmodule

@@ sv/delta_timer_queue.sv @@
`timescale 1ns / 1ps

// delta_timer_queue: sorted queue of waiting ids, each wait kept relative
// to the entry ahead of it, held in a row of QUEUE_DEPTH cells.
// input channel s_*: op (insert, tick, remove), proc_id, wait_ticks.
// result channel m_*: out_id, status, last; last marks the final result of
// an input item. insert and remove give one result, a tick one result per
// expired id (at most 16) or a single "none expired" result.
// an insert or remove enters the head cell and a token walks one cell per
// cycle, while no result waits stalled in m_*, until it finds its place or id;
// an insert into a full queue gives a full result without a walk.
// a tick first decrements the head wait, then pops expired ids from the head.
// a new item is taken once the previous one has produced all its results,
// while the last of them may still wait in m_*.
// when the receiver stalls, one more item may be taken, then the sequencer
// holds with s_ready low until the waiting result is transferred.
// reset empties the queue; cell contents are not cleared.
module delta_timer_queue
    import dtq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [15:0] s_proc_id,
    input  logic [15:0] s_wait_ticks,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_id,
    output logic [2:0]  m_status,
    output logic        m_last
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_POP,
        S_FULL
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [POP_W-1:0] popped_reg, popped_next;
    logic [15:0]      key_reg, key_next;
    logic             ins_reg, ins_next;
    logic             fe_reg, fe_next;
    logic             m_valid_reg, m_valid_next;
    logic [15:0]      out_id_reg, out_id_next;
    logic [2:0]       status_reg, status_next;
    logic             last_reg, last_next;

    dtq_ctl_t               ctl;
    dtq_nbr_t               nbr [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] stop_vec;
    logic [QUEUE_DEPTH-1:0] match_vec;

    logic go;
    logic accept;
    logic any_stop;
    logic found;
    logic head_pops;
    logic next_pops;

    assign go       = !m_valid_reg || m_ready;
    assign s_ready  = state_reg == S_IDLE;
    assign accept   = s_valid && s_ready;
    assign any_stop = (|stop_vec) || nbr[QUEUE_DEPTH-1].fwd;
    assign found    = |match_vec;

    // tick pop decisions at the head of the row
    assign head_pops = count_reg != '0 && popped_reg < POP_W'(MAX_RESULTS)
                       && nbr[0].delta == 16'd0;
    assign next_pops = count_reg > CNT_W'(1) && nbr[1].delta == 16'd0
                       && popped_reg < POP_W'(MAX_RESULTS - 1);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        popped_next  = popped_reg;
        key_next     = key_reg;
        ins_next     = ins_reg;
        fe_next      = fe_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_id_next  = out_id_reg;
        status_next  = status_reg;
        last_next    = last_reg;

        ctl          = '0;
        ctl.ins      = ins_reg;
        ctl.fe       = fe_reg;
        ctl.key      = key_reg;
        ctl.found    = found;
        ctl.init_rem = s_wait_ticks;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    key_next = s_proc_id;
                    case (s_op)
                        OP_INSERT: begin
                            ins_next = 1'b1;
                            fe_next  = s_wait_ticks == FOREVER;
                            if (count_reg == FULL_CNT) begin
                                state_next = S_FULL;
                            end else begin
                                ctl.start  = 1'b1;
                                state_next = S_WALK;
                            end
                        end
                        OP_REMOVE: begin
                            ins_next   = 1'b0;
                            fe_next    = 1'b0;
                            ctl.start  = 1'b1;
                            state_next = S_WALK;
                        end
                        OP_TICK: begin
                            ctl.dec     = 1'b1;
                            popped_next = '0;
                            state_next  = S_POP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (go) begin
                    ctl.step = 1'b1;
                    if (any_stop) begin
                        ctl.apply    = 1'b1;
                        m_valid_next = 1'b1;
                        out_id_next  = key_reg;
                        last_next    = 1'b1;
                        state_next   = S_IDLE;
                        if (ins_reg) begin
                            status_next = ST_OK;
                            count_next  = count_reg + CNT_W'(1);
                        end else if (found) begin
                            status_next = ST_OK;
                            count_next  = count_reg - CNT_W'(1);
                        end else begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                end
            end
            S_POP: begin
                if (go) begin
                    m_valid_next = 1'b1;
                    if (head_pops) begin
                        ctl.pop     = 1'b1;
                        out_id_next = nbr[0].id;
                        status_next = ST_EXPIRED;
                        last_next   = !next_pops;
                        count_next  = count_reg - CNT_W'(1);
                        popped_next = popped_reg + POP_W'(1);
                        if (!next_pops) begin
                            state_next = S_IDLE;
                        end
                    end else begin
                        out_id_next = 16'd0;
                        status_next = ST_NONE;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_FULL: begin
                if (go) begin
                    m_valid_next = 1'b1;
                    out_id_next  = key_reg;
                    status_next  = ST_FULL;
                    last_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            popped_reg  <= '0;
            key_reg     <= '0;
            ins_reg     <= 1'b0;
            fe_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            out_id_reg  <= '0;
            status_reg  <= ST_OK;
            last_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            popped_reg  <= popped_next;
            key_reg     <= key_next;
            ins_reg     <= ins_next;
            fe_reg      <= fe_next;
            m_valid_reg <= m_valid_next;
            out_id_reg  <= out_id_next;
            status_reg  <= status_next;
            last_reg    <= last_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_out_id = out_id_reg;
    assign m_status = status_reg;
    assign m_last   = last_reg;

    // row of queue cells, head at index 0
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        dtq_nbr_t left_n;
        dtq_nbr_t right_n;

        if (k == 0) begin : g_head
            assign left_n = '0;
        end else begin : g_mid
            assign left_n = nbr[k-1];
        end

        if (k == QUEUE_DEPTH - 1) begin : g_tail
            assign right_n = '0;
        end else begin : g_body
            assign right_n = nbr[k+1];
        end

        dtq_cell #(
            .CNT_W (CNT_W),
            .IDX   (k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .count   (count_reg),
            .left_n  (left_n),
            .right_n (right_n),
            .self_n  (nbr[k]),
            .stop    (stop_vec[k]),
            .match   (match_vec[k])
        );
    end

endmodule

@@ sv/dtq_checker.sv @@
`timescale 1ns / 1ps

`include "delta_timer_queue_assert.svh"

module dtq_checker
    import dtq_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_op,
    input logic [15:0] s_proc_id,
    input logic [15:0] s_wait_ticks,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_out_id,
    input logic [2:0]  m_status,
    input logic        m_last
);

    logic        s_stall;
    logic        m_stall;
    logic [33:0] item_bus;
    logic [19:0] result_bus;

    // waiting transfers and their payloads
    assign s_stall    = s_valid && !s_ready;
    assign m_stall    = m_valid && !m_ready;
    assign item_bus   = {s_op, s_proc_id, s_wait_ticks};
    assign result_bus = {m_out_id, m_status, m_last};

    // an offered item holds until its transfer
    `DTQ_ASSERT_NEXT(a_input_hold, aclk, aresetn, s_stall, s_valid && $stable(item_bus))

    // a stalled result holds
    `DTQ_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_stall, m_valid && $stable(result_bus))

    // only expired results can continue a burst
    `DTQ_ASSERT_NOW(a_single_last, aclk, aresetn, m_valid && m_status != ST_EXPIRED, m_last)

    // nothing-expired result carries a zero id
    `DTQ_ASSERT_NOW(a_none_zero, aclk, aresetn, m_valid && m_status == ST_NONE, m_out_id == 16'd0)

    // no new item is taken while a tick burst is still running
    `DTQ_ASSERT_NOW(a_burst_busy, aclk, aresetn, m_valid && !m_last, !s_ready)

endmodule

bind delta_timer_queue dtq_checker u_dtq_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_op         (s_op),
    .s_proc_id    (s_proc_id),
    .s_wait_ticks (s_wait_ticks),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_id     (m_out_id),
    .m_status     (m_status),
    .m_last       (m_last)
);
